// File: sv/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
// Holds the button count, field widths, register indexes and event codes.
// No dependencies; every other file of the block imports this package.
package bdpc_pkg;

  localparam int BUTTON_COUNT = 2;
  localparam int PIN_BITS     = 2;
  localparam int BTN_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int PIN_EXT_W    = 1 << BTN_W;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_LIMIT = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] DEBOUNCE_LIMIT_RESET   = CNT_W'(3);
  localparam logic [CNT_W-1:0] LONG_PRESS_LIMIT_RESET = CNT_W'(150);

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_t;

  typedef struct packed {
    logic                cmd;
    logic [PIN_BITS-1:0] pin_levels;
    logic                read_button;
  } in_item_t;

  typedef struct packed {
    ev_t  event_code;
    logic result_button;
  } result_t;

endpackage

// File: sv/bdpc_in_stage.sv
// Input register of the button classifier: holds one accepted item.
// Frees itself when the core moves the item on to the result register.
// Depends on bdpc_pkg for the item type.
module bdpc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdpc_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               held_valid,
  output bdpc_pkg::in_item_t held_item
);
  import bdpc_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: sv/bdpc_core.sv
// Per-button debounce and press classification state with its update logic.
// Holds the configuration registers and does one scan or read per fire.
// Depends on bdpc_pkg for types, widths and codes.
module bdpc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           fire,
  input  bdpc_pkg::in_item_t             item,
  output bdpc_pkg::result_t              result
);
  import bdpc_pkg::*;

  logic [CNT_W-1:0] debounce_limit;
  logic [CNT_W-1:0] long_press_limit;
  logic [BTN_W-1:0] scan_pointer;
  logic [CNT_W-1:0] debounce_counter [BUTTON_COUNT];
  logic [CNT_W-1:0] hold_counter     [BUTTON_COUNT];
  ev_t              pending_event    [BUTTON_COUNT];
  logic             accepted_level   [BUTTON_COUNT];

  logic [PIN_EXT_W-1:0] pin_ext;
  logic [BTN_W-1:0] pointer_next;
  logic [BTN_W-1:0] rb_idx;
  logic             rb_ok;
  logic             level;
  logic [CNT_W-1:0] dc_cur;
  logic [CNT_W-1:0] dc_inc;
  logic [CNT_W-1:0] hold_cur;
  logic [CNT_W-1:0] hold_inc;
  logic             acc_cur;
  logic [CNT_W-1:0] dc_next;
  logic [CNT_W-1:0] hold_next;
  logic             acc_next;
  logic             ev_we;
  ev_t              ev_val;

  // Buttons beyond the pin field read as released.
  assign pin_ext = PIN_EXT_W'({{PIN_EXT_W{LEVEL_RELEASED}}, item.pin_levels});
  assign level   = pin_ext[scan_pointer];

  assign pointer_next = (32'(scan_pointer) == BUTTON_COUNT - 1) ? '0
                                                                : scan_pointer + 1'b1;
  assign rb_idx   = BTN_W'(item.read_button);
  assign rb_ok    = 32'(item.read_button) < BUTTON_COUNT;

  assign dc_cur   = debounce_counter[scan_pointer];
  assign hold_cur = hold_counter[scan_pointer];
  assign acc_cur  = accepted_level[scan_pointer];
  assign dc_inc   = dc_cur + 1'b1;
  assign hold_inc = hold_cur + 1'b1;

  always_comb begin
    dc_next   = dc_cur;
    hold_next = hold_cur;
    acc_next  = acc_cur;
    ev_we     = 1'b0;
    ev_val    = EV_NONE;
    if (level == acc_cur) begin
      dc_next = '0;
      if (level == LEVEL_PRESSED && hold_cur < long_press_limit) begin
        hold_next = hold_inc;
        if (hold_inc == long_press_limit) begin
          ev_we  = 1'b1;
          ev_val = EV_LONG;
        end
      end
    end else if (dc_inc == debounce_limit) begin
      // New level accepted; a release before the long count is a short press.
      acc_next  = level;
      dc_next   = '0;
      hold_next = '0;
      if (level == LEVEL_RELEASED && hold_cur < long_press_limit) begin
        ev_we  = 1'b1;
        ev_val = EV_SHORT;
      end
    end else begin
      dc_next = dc_inc;
    end
  end

  always_comb begin
    if (item.cmd == CMD_SCAN) begin
      result.event_code    = EV_NONE;
      result.result_button = scan_pointer[0];
    end else begin
      result.event_code    = rb_ok ? pending_event[rb_idx] : EV_NONE;
      result.result_button = item.read_button;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit   <= DEBOUNCE_LIMIT_RESET;
      long_press_limit <= LONG_PRESS_LIMIT_RESET;
      scan_pointer     <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        debounce_counter[i] <= '0;
        hold_counter[i]     <= '0;
        pending_event[i]    <= EV_NONE;
        accepted_level[i]   <= LEVEL_RELEASED;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DEBOUNCE_LIMIT) begin
          debounce_limit <= cfg_data;
        end else if (cfg_index == REG_LONG_PRESS_LIMIT) begin
          long_press_limit <= cfg_data;
        end
      end
      if (fire) begin
        if (item.cmd == CMD_SCAN) begin
          debounce_counter[scan_pointer] <= dc_next;
          hold_counter[scan_pointer]     <= hold_next;
          accepted_level[scan_pointer]   <= acc_next;
          if (ev_we) begin
            pending_event[scan_pointer] <= ev_val;
          end
          scan_pointer <= pointer_next;
        end else if (rb_ok) begin
          pending_event[rb_idx] <= EV_NONE;
        end
      end
    end
  end

endmodule

// File: sv/button_debounce_press_classifier.sv
// Debounces active-low buttons and classifies presses as short or long. Each transfer on the
// input stream is either a scan tick, which updates the next button in round-robin order and
// returns a result with no event, or a read, which returns and clears one button's pending
// event. Exactly one result transfer follows each input transfer, in order. The block takes
// one item per clock cycle while no result waits on m_tready, a rate set by the
// read-modify-write of the addressed button's counters. Each item passes the input register
// and then the result register before its result is presented. When a result waits on
// m_tready and the input register is also full, s_tready drops until the result is taken.
// Configuration writes (debounce_limit at index 0, long_press_limit at index 1) are always
// accepted and must be made while no item is in flight.
// Depends on bdpc_pkg, bdpc_in_stage and bdpc_core.
module button_debounce_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [1:0] pin_levels, [2] read_button
  input  logic                           s_tuser,   // [0] cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [1:0] event_code, [2] result_button
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdpc_pkg::CNT_W-1:0]     cfg_data
);
  import bdpc_pkg::*;

  in_item_t s_item;
  in_item_t held_item;
  logic     held_valid;
  logic     advance;
  result_t  core_result;

  assign s_item.cmd         = s_tuser;
  assign s_item.pin_levels  = s_tdata[PIN_BITS-1:0];
  assign s_item.read_button = s_tdata[PIN_BITS];

  assign cfg_ready = 1'b1;

  // The held item moves on whenever the result register is free or being drained.
  assign advance = held_valid && (!m_tvalid || m_tready);

  bdpc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (s_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  bdpc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (held_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {5'd0, core_result.result_button, core_result.event_code};
    end
  end

  a_out_after_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded after item advanced");

  a_stall_means_held: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (held_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  a_event_code_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("illegal event code on output");

  a_scan_no_event: assert property (@(posedge clk) disable iff (rst)
    (advance && held_item.cmd == CMD_SCAN) |=> (m_tdata[1:0] == 2'd0))
    else $error("scan tick produced an event");

endmodule

// File: tb/sv/button_debounce_press_classifier_tb.sv
// Self-checking testbench for button_debounce_press_classifier.
// Predicts every result transfer with a scoreboard class and drives scans and reads under
// several limit settings and handshake idling patterns. Depends on bdpc_pkg and the block.
module button_debounce_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpc_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASES         = 8;
  localparam int PRESSURE_PHASE = 4;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class press_scoreboard;
    logic [CNT_W-1:0] deb_limit;
    logic [CNT_W-1:0] long_limit;
    logic [BTN_W-1:0] scan_ptr;
    logic [CNT_W-1:0] deb_cnt  [BUTTON_COUNT];
    logic [CNT_W-1:0] hold_cnt [BUTTON_COUNT];
    ev_t              pend_ev  [BUTTON_COUNT];
    logic             level_q  [BUTTON_COUNT];
    result_t          results_due[$];
    int               errors;

    function new();
      deb_limit  = DEBOUNCE_LIMIT_RESET;
      long_limit = LONG_PRESS_LIMIT_RESET;
      scan_ptr   = '0;
      errors     = 0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        deb_cnt[b]  = '0;
        hold_cnt[b] = '0;
        pend_ev[b]  = EV_NONE;
        level_q[b]  = LEVEL_RELEASED;
      end
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      if (idx == REG_DEBOUNCE_LIMIT) begin
        deb_limit = val;
      end else if (idx == REG_LONG_PRESS_LIMIT) begin
        long_limit = val;
      end
    endfunction

    // Counters are 8 bits wide and wrap, so a debounce limit of zero takes 256 scans.
    function void scan_button(int b, logic lvl);
      if (lvl == level_q[b]) begin
        deb_cnt[b] = '0;
        if (lvl == LEVEL_PRESSED && hold_cnt[b] < long_limit) begin
          hold_cnt[b] = hold_cnt[b] + 1'b1;
          if (hold_cnt[b] == long_limit) pend_ev[b] = EV_LONG;
        end
      end else begin
        deb_cnt[b] = deb_cnt[b] + 1'b1;
        if (deb_cnt[b] == deb_limit) begin
          level_q[b] = lvl;
          deb_cnt[b] = '0;
          if (lvl == LEVEL_RELEASED && hold_cnt[b] < long_limit) pend_ev[b] = EV_SHORT;
          hold_cnt[b] = '0;
        end
      end
    endfunction

    function void note_item(logic cmd, logic [PIN_BITS-1:0] pins, logic rb);
      result_t r;
      int      b;
      if (cmd == CMD_SCAN) begin
        b = int'(scan_ptr);
        if (b >= BUTTON_COUNT) b = 0;
        scan_button(b, (b < PIN_BITS) ? pins[b] : LEVEL_RELEASED);
        scan_ptr = (b + 1 >= BUTTON_COUNT) ? '0 : BTN_W'(b + 1);
        r.event_code    = EV_NONE;
        r.result_button = 1'(b);
      end else begin
        r.event_code    = EV_NONE;
        r.result_button = rb;
        if (int'(rb) < BUTTON_COUNT) begin
          r.event_code = pend_ev[rb];
          pend_ev[rb]  = EV_NONE;
        end
      end
      results_due.push_back(r);
    endfunction

    function void check_result(logic [7:0] data);
      result_t exp;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: tdata 0x%02h", data);
        errors++;
        return;
      end
      exp = results_due.pop_front();
      if (data[1:0] !== exp.event_code) begin
        $error("event_code: expected %0d, got %0d", exp.event_code, data[1:0]);
        errors++;
      end
      if (data[2] !== exp.result_button) begin
        $error("result_button: expected %0d, got %0d", exp.result_button, data[2]);
        errors++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  press_scoreboard board;
  idle_mode_t      idle_mode = IDLE_NONE;
  int              long_stall_left = 0;

  int unsigned deb_set   [PHASES] = '{3, 1, 2, 5, 0, 255, 1, 4};
  int unsigned long_set  [PHASES] = '{150, 1, 8, 3, 0, 255, 255, 40};
  int          phase_items[PHASES] = '{80, 200, 120, 120, 500, 40, 300, 120};

  button_debounce_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit sender_idles();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 87;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 28;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls();
    if (idle_mode == IDLE_RECEIVER) return $urandom_range(99) < 87;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 28;
    return 1'b0;
  endfunction

  // The long hold-off keeps the output side blocked while items keep coming in.
  always @(negedge clk) begin
    if (long_stall_left > 0) begin
      long_stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !receiver_stalls();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("button_debounce_press_classifier_tb: done, errors");
    $finish;
  end

  // Starts and ends at a falling edge; tvalid stays high after the transfer.
  task automatic send_item(input logic cmd, input logic [PIN_BITS-1:0] pins, input logic rb);
    while (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, rb, pins};
    do @(posedge clk); while (!s_tready);
    board.note_item(cmd, pins, rb);
    @(negedge clk);
  endtask

  task automatic send_run(input logic cmd, input logic [PIN_BITS-1:0] pins, input logic rb,
                          input int count);
    repeat (count) send_item(cmd, pins, rb);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_limit(idx, val);
    @(negedge clk);
  endtask

  task automatic directed_checks();
    send_item(CMD_READ, 2'b11, 1'b0);
    send_item(CMD_READ, 2'b00, 1'b1);
    send_run(CMD_SCAN, 2'b00, 1'b0, 6);
    send_run(CMD_SCAN, 2'b11, 1'b1, 6);
    send_item(CMD_READ, 2'b01, 1'b0);
    send_item(CMD_READ, 2'b10, 1'b0);
    send_item(CMD_READ, 2'b11, 1'b1);
    // A short bounce on button 0 must not be accepted.
    send_run(CMD_SCAN, 2'b10, 1'b0, 2);
    send_run(CMD_SCAN, 2'b11, 1'b1, 2);
    send_item(CMD_READ, 2'b00, 1'b1);
    send_item(CMD_READ, 2'b11, 1'b0);
  endtask

  // Mostly clean press and release runs with rare bounces, plus reads and pin noise.
  task automatic run_presses(input int count);
    logic [PIN_BITS-1:0] target;
    logic [PIN_BITS-1:0] pins;
    int                  hold_left [PIN_BITS];
    int                  deb_eff;
    int                  span;
    int                  roll;
    int                  k;
    int                  n;
    deb_eff = (board.deb_limit == 0) ? 256 : int'(board.deb_limit);
    span    = 2 * BUTTON_COUNT * (deb_eff + int'(board.long_limit)) + 4;
    target  = '1;
    for (k = 0; k < PIN_BITS; k++) hold_left[k] = $urandom_range(1, span);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_item(CMD_READ, PIN_BITS'($urandom), 1'($urandom));
      end else if (roll < 20 && deb_eff <= 32) begin
        send_item(CMD_SCAN, PIN_BITS'($urandom), 1'($urandom));
      end else begin
        for (k = 0; k < PIN_BITS; k++) begin
          hold_left[k]--;
          if (hold_left[k] <= 0) begin
            target[k]    = ~target[k];
            hold_left[k] = $urandom_range(1, span);
          end
        end
        pins = target;
        if ($urandom_range(0, 4 * deb_eff) == 0) pins[$urandom_range(PIN_BITS - 1)] ^= 1'b1;
        send_item(CMD_SCAN, pins, 1'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_SCAN;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE_LIMIT;
    cfg_data  = '0;
    board     = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_checks();
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(REG_DEBOUNCE_LIMIT, CNT_W'(deb_set[p]));
        write_reg(REG_LONG_PRESS_LIMIT, CNT_W'(long_set[p]));
        cfg_valid <= 1'b0;
      end
      idle_mode = idle_mode_t'(p % 4);
      if (p == PRESSURE_PHASE) long_stall_left = 300;
      run_presses(phase_items[p]);
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0) begin
      $display("button_debounce_press_classifier_tb: done, clean");
    end else begin
      $display("button_debounce_press_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/bdpc_pkg.sv
sv/bdpc_in_stage.sv
sv/bdpc_core.sv
sv/button_debounce_press_classifier.sv
tb/sv/button_debounce_press_classifier_tb.sv
